// File: rtl/twts_pkg.sv
// Shared types, constants and a helper function for the timing wheel timer scheduler.
// No dependencies; every other file of the block but twts_ram refers to this package by scoped name.

package twts_pkg;

    localparam int NUM_TIMERS   = 16;
    localparam int WHEEL_SPAN   = 256;
    localparam int BUCKET_TICKS = 1;
    localparam int MAX_OUT      = 16;

    localparam int TIME_W = 48;
    localparam int IDX_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W  = $clog2(MAX_OUT + 1);
    localparam int BKT_W  = $clog2(WHEEL_SPAN);

    // request commands
    localparam logic [1:0] CMD_TICK       = 2'd0;
    localparam logic [1:0] CMD_REGISTER   = 2'd1;
    localparam logic [1:0] CMD_UNREGISTER = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_FIRED        = 2'd0;
    localparam logic [1:0] KIND_REGISTERED   = 2'd1;
    localparam logic [1:0] KIND_REJECTED     = 2'd2;
    localparam logic [1:0] KIND_UNREGISTERED = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  timer_id;
        logic [31:0] start_delay;
        logic [31:0] period;
        logic [31:0] user_tag;
    } req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  out_id;
        logic [31:0] out_tag;
        logic        last;
    } res_t;

    typedef struct packed {
        logic [TIME_W-1:0] deadline;
        logic [31:0]       interval;
        logic [31:0]       tag;
    } timer_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMD_RD,
        ST_CMD_EX,
        ST_SCAN_RD,
        ST_SCAN,
        ST_FLUSH
    } ctrl_state_t;

    typedef struct packed {
        logic             load_req;
        logic             rd_sel_id;
        logic [IDX_W-1:0] rd_idx;
        logic             cmd_exec;
        logic             fire;
        logic             push_held;
        logic             push_last;
        logic             finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic due;
        logic held_valid;
        logic res_free;
    } dp_status_t;

    function automatic logic [BKT_W-1:0] bucket_of(input logic [TIME_W-1:0] t);
        logic [TIME_W-1:0] m;
        m = t % TIME_W'(WHEEL_SPAN);
        return BKT_W'(m / TIME_W'(BUCKET_TICKS));
    endfunction

endpackage

// File: rtl/twts_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.

module twts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/twts_ctrl.sv
// Controller state machine: request acceptance, table scan sequencing, result hand-off.
// Depends on twts_pkg.

module twts_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    input  logic [1:0]             req_cmd,
    input  logic [3:0]             req_id,
    input  twts_pkg::dp_status_t   sts,
    output logic                   req_stall,
    output twts_pkg::ctrl_cmd_t    ctl
);

    localparam logic [twts_pkg::IDX_W-1:0] LAST_IDX = twts_pkg::IDX_W'(twts_pkg::NUM_TIMERS - 1);

    twts_pkg::ctrl_state_t        state_reg, state_next;
    logic [twts_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic                         id_ok;
    logic                         advance;

    assign id_ok = (32'(req_id) < 32'(twts_pkg::NUM_TIMERS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= twts_pkg::ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        ctl        = '0;
        ctl.rd_idx = idx_reg;
        req_stall  = 1'b1;
        advance    = 1'b0;

        case (state_reg)
            twts_pkg::ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    ctl.load_req = 1'b1;
                    case (req_cmd)
                        twts_pkg::CMD_TICK:
                        begin
                            idx_next   = '0;
                            state_next = twts_pkg::ST_SCAN_RD;
                        end
                        twts_pkg::CMD_REGISTER, twts_pkg::CMD_UNREGISTER:
                        begin
                            if (id_ok)
                            begin
                                state_next = twts_pkg::ST_CMD_RD;
                            end
                        end
                        default:
                        begin
                            state_next = twts_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            twts_pkg::ST_CMD_RD:
            begin
                ctl.rd_sel_id = 1'b1;
                state_next    = twts_pkg::ST_CMD_EX;
            end

            twts_pkg::ST_CMD_EX:
            begin
                ctl.rd_sel_id = 1'b1;
                if (sts.res_free)
                begin
                    ctl.cmd_exec = 1'b1;
                    state_next   = twts_pkg::ST_IDLE;
                end
            end

            twts_pkg::ST_SCAN_RD:
            begin
                state_next = twts_pkg::ST_SCAN;
            end

            twts_pkg::ST_SCAN:
            begin
                // read data belongs to idx_reg; the held result goes out once a newer one exists
                if (!sts.due)
                begin
                    advance = 1'b1;
                end
                else if (!sts.held_valid)
                begin
                    ctl.fire = 1'b1;
                    advance  = 1'b1;
                end
                else if (sts.res_free)
                begin
                    ctl.push_held = 1'b1;
                    ctl.fire      = 1'b1;
                    advance       = 1'b1;
                end

                if (advance)
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = twts_pkg::ST_FLUSH;
                    end
                    else
                    begin
                        idx_next   = idx_reg + twts_pkg::IDX_W'(1);
                        ctl.rd_idx = idx_reg + twts_pkg::IDX_W'(1);
                    end
                end
            end

            twts_pkg::ST_FLUSH:
            begin
                if (!sts.held_valid)
                begin
                    ctl.finish = 1'b1;
                    state_next = twts_pkg::ST_IDLE;
                end
                else if (sts.res_free)
                begin
                    ctl.push_held = 1'b1;
                    ctl.push_last = 1'b1;
                    ctl.finish    = 1'b1;
                    state_next    = twts_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = twts_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/twts_datapath.sv
// Datapath: timer table RAM, armed bits, current time, held fire result, result register.
// Depends on twts_pkg and twts_ram.

module twts_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  twts_pkg::ctrl_cmd_t   ctl,
    input  twts_pkg::req_t        req_data,
    input  logic                  res_stall,
    output twts_pkg::dp_status_t  sts,
    output logic                  res_valid,
    output twts_pkg::res_t        res_data
);

    twts_pkg::req_t                    req_reg;
    logic [twts_pkg::TIME_W-1:0]       now_reg, now_next;
    logic [twts_pkg::NUM_TIMERS-1:0]   armed_reg, armed_next;
    logic [twts_pkg::IDX_W-1:0]        rd_idx_q_reg;
    logic                              held_valid_reg, held_valid_next;
    logic [twts_pkg::IDX_W-1:0]        held_id_reg;
    logic [31:0]                       held_tag_reg;
    logic [twts_pkg::CNT_W-1:0]        fire_cnt_reg, fire_cnt_next;
    logic                              res_valid_reg, res_valid_next;
    twts_pkg::res_t                    res_reg, res_next;

    logic [twts_pkg::IDX_W-1:0]        ram_rd_addr;
    logic [$bits(twts_pkg::timer_entry_t)-1:0] ram_rd_data;
    twts_pkg::timer_entry_t            entry;
    twts_pkg::timer_entry_t            wr_entry;
    logic                              wr_en;
    logic                              cur_armed;
    logic                              res_load;

    assign ram_rd_addr = ctl.rd_sel_id ? twts_pkg::IDX_W'(req_reg.timer_id) : ctl.rd_idx;
    assign entry       = twts_pkg::timer_entry_t'(ram_rd_data);
    assign cur_armed   = armed_reg[rd_idx_q_reg];

    twts_ram #(
        .WIDTH ($bits(twts_pkg::timer_entry_t)),
        .DEPTH (twts_pkg::NUM_TIMERS)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (rd_idx_q_reg),
        .wr_data (wr_entry),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        sts.due = cur_armed
               && (twts_pkg::bucket_of(entry.deadline) == twts_pkg::bucket_of(now_reg))
               && (entry.deadline <= now_reg)
               && (fire_cnt_reg < twts_pkg::CNT_W'(twts_pkg::MAX_OUT));
        sts.held_valid = held_valid_reg;
        sts.res_free   = !res_valid_reg || !res_stall;
    end

    always_comb
    begin
        now_next        = now_reg;
        armed_next      = armed_reg;
        held_valid_next = held_valid_reg;
        fire_cnt_next   = fire_cnt_reg;
        wr_en           = 1'b0;
        wr_entry        = entry;
        res_load        = 1'b0;
        res_next        = res_reg;

        if (ctl.load_req)
        begin
            fire_cnt_next = '0;
        end

        if (ctl.cmd_exec)
        begin
            res_load        = 1'b1;
            res_next.out_id = req_reg.timer_id;
            res_next.last   = 1'b1;
            if (req_reg.cmd == twts_pkg::CMD_REGISTER)
            begin
                if (cur_armed)
                begin
                    res_next.kind    = twts_pkg::KIND_REJECTED;
                    res_next.out_tag = entry.tag;
                end
                else
                begin
                    armed_next[rd_idx_q_reg] = 1'b1;
                    wr_en             = 1'b1;
                    wr_entry.deadline = now_reg + twts_pkg::TIME_W'(req_reg.start_delay);
                    wr_entry.interval = req_reg.period;
                    wr_entry.tag      = req_reg.user_tag;
                    res_next.kind     = twts_pkg::KIND_REGISTERED;
                    res_next.out_tag  = req_reg.user_tag;
                end
            end
            else
            begin
                res_next.kind            = twts_pkg::KIND_UNREGISTERED;
                res_next.out_tag         = cur_armed ? entry.tag : 32'd0;
                armed_next[rd_idx_q_reg] = 1'b0;
            end
        end

        if (ctl.push_held)
        begin
            res_load         = 1'b1;
            res_next.kind    = twts_pkg::KIND_FIRED;
            res_next.out_id  = 4'(held_id_reg);
            res_next.out_tag = held_tag_reg;
            res_next.last    = ctl.push_last;
            held_valid_next  = 1'b0;
        end

        if (ctl.fire)
        begin
            held_valid_next = 1'b1;
            fire_cnt_next   = fire_cnt_reg + twts_pkg::CNT_W'(1);
            if (entry.interval == 32'd0)
            begin
                armed_next[rd_idx_q_reg] = 1'b0;
            end
            else
            begin
                wr_en             = 1'b1;
                wr_entry.deadline = entry.deadline + twts_pkg::TIME_W'(entry.interval);
            end
        end

        if (ctl.finish)
        begin
            now_next = now_reg + twts_pkg::TIME_W'(1);
        end

        res_valid_next = res_load ? 1'b1 : (res_valid_reg && res_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg        <= '0;
            armed_reg      <= '0;
            held_valid_reg <= 1'b0;
            fire_cnt_reg   <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            now_reg        <= now_next;
            armed_reg      <= armed_next;
            held_valid_reg <= held_valid_next;
            fire_cnt_reg   <= fire_cnt_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_req)
        begin
            req_reg <= req_data;
        end
        if (ctl.fire)
        begin
            held_id_reg  <= rd_idx_q_reg;
            held_tag_reg <= entry.tag;
        end
        rd_idx_q_reg <= ram_rd_addr;
        res_reg      <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

endmodule

// File: rtl/timing_wheel_timer_scheduler_unit.sv
// Timing wheel timer scheduler, top level: controller plus datapath.
// Register/unregister: the request is registered, the table entry read and, once the result register
// is free, executed; no new request is taken until the result is loaded. Tick: the timer table RAM
// read port scans one entry per cycle while no result stall holds it, then the held result goes out.
// Reset clears the time, the armed bits and all control; table contents are not cleared.
// Depends on twts_pkg, twts_ctrl, twts_datapath, twts_ram.

module timing_wheel_timer_scheduler_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  twts_pkg::req_t  req_data,
    output logic            res_valid,
    input  logic            res_stall,
    output twts_pkg::res_t  res_data
);

    twts_pkg::ctrl_cmd_t  ctl;
    twts_pkg::dp_status_t sts;

    twts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_cmd   (req_data.cmd),
        .req_id    (req_data.timer_id),
        .sts       (sts),
        .req_stall (req_stall),
        .ctl       (ctl)
    );

    twts_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .req_data  (req_data),
        .res_stall (res_stall),
        .sts       (sts),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

endmodule

// File: rtl/twts_checker.sv
// Port-level checks for the timer scheduler, bound to the top level.
// Depends on twts_pkg and timing_wheel_timer_scheduler_unit.

module twts_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  logic            req_stall,
    input  twts_pkg::req_t  req_data,
    input  logic            res_valid,
    input  logic            res_stall,
    input  twts_pkg::res_t  res_data
);

    // a tick request always occupies the block for its scan
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && (req_data.cmd == twts_pkg::CMD_TICK) |=> req_stall)
        else $error("tick request did not start a scan");

    // results only come out of a request in progress
    a_res_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(req_stall))
        else $error("result appeared while idle");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("stalled result changed");

    // register/unregister results (registered, rejected, unregistered) always carry last
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_data.kind != twts_pkg::KIND_FIRED) |-> res_data.last)
        else $error("non-fire result without last");

endmodule

bind timing_wheel_timer_scheduler_unit twts_checker u_chk (.*);

// File: verif/timing_wheel_timer_scheduler_unit_tb.sv
// Self-checking testbench for the timing wheel timer scheduler unit.
// A queue-fed driver, a stalling monitor and a software copy of the timer table predict
// every result. Depends on twts_pkg and the timing_wheel_timer_scheduler_unit RTL.

module timing_wheel_timer_scheduler_unit_tb;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 2000;
    localparam int ITEM_TARGET = 420;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    twts_pkg::req_t req_data = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    twts_pkg::res_t res_data;

    timing_wheel_timer_scheduler_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    always #6 clk = ~clk;

    // software copy of the timer table
    logic [twts_pkg::TIME_W-1:0] wheel_now;
    logic                        tmr_armed [twts_pkg::NUM_TIMERS];
    logic [twts_pkg::TIME_W-1:0] tmr_deadline [twts_pkg::NUM_TIMERS];
    logic [31:0]                 tmr_interval [twts_pkg::NUM_TIMERS];
    logic [31:0]                 tmr_tag [twts_pkg::NUM_TIMERS];

    twts_pkg::req_t pending_reqs [$];
    twts_pkg::res_t expected_events [$];
    int   errors = 0;
    int   n_items = 0;

    function automatic logic [twts_pkg::TIME_W-1:0] wheel_bucket(
        input logic [twts_pkg::TIME_W-1:0] t);
        return (t % twts_pkg::TIME_W'(twts_pkg::WHEEL_SPAN))
               / twts_pkg::TIME_W'(twts_pkg::BUCKET_TICKS);
    endfunction

    function automatic void push_event(input logic [1:0] kind, input int id,
                                       input logic [31:0] tag, input logic last);
        twts_pkg::res_t ev;
        ev.kind    = kind;
        ev.out_id  = 4'(id);
        ev.out_tag = tag;
        ev.last    = last;
        expected_events.insert(expected_events.size(), ev);
    endfunction

    function automatic void schedule_request(input twts_pkg::req_t r);
        logic [twts_pkg::NUM_TIMERS-1:0] due;
        int id;
        int n;
        id = int'(r.timer_id);
        due = '0;
        n = 0;
        case (r.cmd)
            twts_pkg::CMD_TICK:
            begin
                for (int i = 0; i < twts_pkg::NUM_TIMERS; i++)
                begin
                    if (tmr_armed[i] && n < twts_pkg::MAX_OUT &&
                        wheel_bucket(tmr_deadline[i]) == wheel_bucket(wheel_now) &&
                        tmr_deadline[i] <= wheel_now)
                    begin
                        due[i] = 1'b1;
                        n++;
                    end
                end
                for (int i = 0; i < twts_pkg::NUM_TIMERS; i++)
                begin
                    if (due[i])
                    begin
                        push_event(twts_pkg::KIND_FIRED, i, tmr_tag[i],
                                   (due >> (i + 1)) == '0);
                        if (tmr_interval[i] == 32'd0)
                            tmr_armed[i] = 1'b0;
                        else
                            tmr_deadline[i] = tmr_deadline[i]
                                              + twts_pkg::TIME_W'(tmr_interval[i]);
                    end
                end
                wheel_now = wheel_now + twts_pkg::TIME_W'(1);
            end
            twts_pkg::CMD_REGISTER:
            begin
                if (id < twts_pkg::NUM_TIMERS)
                begin
                    if (tmr_armed[id])
                    begin
                        push_event(twts_pkg::KIND_REJECTED, id, tmr_tag[id], 1'b1);
                    end
                    else
                    begin
                        tmr_armed[id] = 1'b1;
                        tmr_deadline[id] = wheel_now + twts_pkg::TIME_W'(r.start_delay);
                        tmr_interval[id] = r.period;
                        tmr_tag[id] = r.user_tag;
                        push_event(twts_pkg::KIND_REGISTERED, id, r.user_tag, 1'b1);
                    end
                end
            end
            twts_pkg::CMD_UNREGISTER:
            begin
                if (id < twts_pkg::NUM_TIMERS)
                begin
                    push_event(twts_pkg::KIND_UNREGISTERED, id,
                               tmr_armed[id] ? tmr_tag[id] : 32'd0, 1'b1);
                    tmr_armed[id] = 1'b0;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void add_req(input logic [1:0] cmd, input logic [3:0] id,
                                    input logic [31:0] delay, input logic [31:0] per,
                                    input logic [31:0] tag);
        twts_pkg::req_t r;
        r.cmd = cmd;
        r.timer_id = id;
        r.start_delay = delay;
        r.period = per;
        r.user_tag = tag;
        pending_reqs.insert(pending_reqs.size(), r);
        if (cmd != CMD_UNUSED)
            n_items++;
    endfunction

    function automatic void add_tick();
        add_req(twts_pkg::CMD_TICK, 4'($urandom), $urandom, $urandom, $urandom);
    endfunction

    function automatic logic [31:0] pick_delay();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 75)
            return $urandom_range(0, 24);
        else if (sel < 88)
            return $urandom_range(200, 520);
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_period();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 30)
            return 32'd0;
        else if (sel < 75)
            return $urandom_range(1, 16);
        else if (sel < 85)
            return 32'd256;
        return $urandom;
    endfunction

    // driver: bursts of requests separated by random gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_data <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (req_valid && !req_stall)
                schedule_request(req_data);
            if (!req_valid || !req_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    req_valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    req_data <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 16);
                        gap_left <= ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 30);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: result stall pattern picks a new random mode each time mode_cnt wraps
    int stall_mode = 0;
    int mode_cnt = 0;
    int hold_left = 0;

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        twts_pkg::res_t want;
        logic stall_next;
        if (!rst_n)
        begin
            res_stall <= 1'b0;
            stall_mode <= 0;
            mode_cnt <= 0;
            hold_left <= 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (expected_events.size() == 0)
                begin
                    $display({"%0t: unexpected result, expected none ",
                              "actual kind %0d id %0d tag %h last %b"},
                             $time, res_data.kind, res_data.out_id, res_data.out_tag,
                             res_data.last);
                    errors++;
                end
                else
                begin
                    want = expected_events.pop_front();
                    check_field("kind", 32'(want.kind), 32'(res_data.kind));
                    check_field("out_id", 32'(want.out_id), 32'(res_data.out_id));
                    check_field("out_tag", want.out_tag, res_data.out_tag);
                    check_field("last", 32'(want.last), 32'(res_data.last));
                end
            end
            stall_next = 1'b0;
            case (stall_mode)
                1: stall_next = ($urandom_range(0, 2) == 0);
                2: stall_next = (mode_cnt % 5 < 2);
                3:
                begin
                    if (hold_left > 0)
                    begin
                        stall_next = 1'b1;
                        hold_left <= hold_left - 1;
                    end
                    else if ($urandom_range(0, 7) == 0)
                    begin
                        stall_next = 1'b1;
                        hold_left <= $urandom_range(0, 11);
                    end
                end
                default: stall_next = 1'b0;
            endcase
            res_stall <= stall_next;
            if (mode_cnt == 127)
            begin
                mode_cnt <= 0;
                stall_mode <= $urandom_range(0, 3);
            end
            else
            begin
                mode_cnt <= mode_cnt + 1;
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    int idle_cycles = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else if ((req_valid && !req_stall) || (res_valid && !res_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: watchdog expired with %0d results outstanding", $time,
                     expected_events.size());
            $display("== FAIL ==");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int sel;
        int d;
        logic full_done;
        full_done = 1'b0;
        wheel_now = '0;
        for (int i = 0; i < twts_pkg::NUM_TIMERS; i++)
            tmr_armed[i] = 1'b0;

        // directed part
        add_req(twts_pkg::CMD_REGISTER, 4'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
        add_tick();
        // same bucket as now, deadline one wheel turn later: must not fire
        add_req(twts_pkg::CMD_REGISTER, 4'd15, 32'd256, 32'd0, 32'd0);
        add_req(twts_pkg::CMD_REGISTER, 4'd15, 32'd5, 32'd5, 32'h1234_5678);
        add_tick();
        add_req(twts_pkg::CMD_UNREGISTER, 4'd15, 32'd0, 32'd0, 32'd0);
        add_req(twts_pkg::CMD_UNREGISTER, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF);
        add_req(CMD_UNUSED, 4'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_req(twts_pkg::CMD_REGISTER, 4'd3, 32'd1, 32'd1, 32'hA5A5_A5A5);
        add_req(twts_pkg::CMD_REGISTER, 4'd7, 32'd1, 32'd0, 32'h5A5A_5A5A);
        add_tick();
        add_tick();
        add_tick();
        add_req(twts_pkg::CMD_UNREGISTER, 4'd3, 32'd0, 32'd0, 32'd0);
        add_req(twts_pkg::CMD_REGISTER, 4'd9, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0F0F_0F0F);
        add_req(twts_pkg::CMD_REGISTER, 4'd10, 32'd0, 32'hFFFF_FFFF, 32'hF0F0_F0F0);
        add_tick();
        add_tick();
        add_req(twts_pkg::CMD_UNREGISTER, 4'd9, 32'd0, 32'd0, 32'd0);
        add_req(twts_pkg::CMD_UNREGISTER, 4'd10, 32'd0, 32'd0, 32'd0);

        // random part
        while (n_items < ITEM_TARGET)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 2 || (!full_done && n_items > 150))
            begin
                // clear and rearm the whole table so that every timer is due on one tick
                full_done = 1'b1;
                d = $urandom_range(0, 2);
                for (int i = 0; i < twts_pkg::NUM_TIMERS; i++)
                    add_req(twts_pkg::CMD_UNREGISTER, 4'(i), $urandom, $urandom, $urandom);
                for (int i = 0; i < twts_pkg::NUM_TIMERS; i++)
                    add_req(twts_pkg::CMD_REGISTER, 4'(i), d, $urandom_range(0, 3), $urandom);
                repeat (6) add_tick();
            end
            else if (sel < 50)
            begin
                add_tick();
            end
            else if (sel < 75)
            begin
                add_req(twts_pkg::CMD_REGISTER, 4'($urandom), pick_delay(), pick_period(),
                        $urandom);
            end
            else if (sel < 92)
            begin
                add_req(twts_pkg::CMD_UNREGISTER, 4'($urandom), $urandom, $urandom, $urandom);
            end
            else if (sel < 95)
            begin
                add_req(CMD_UNUSED, 4'($urandom), $urandom, $urandom, $urandom);
            end
            else
            begin
                repeat ($urandom_range(5, 40)) add_tick();
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || req_valid)
            @(posedge clk);
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
